// File: rtl/assert_macros.svh
// assertion macros shared by the rtl files
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// implication checked on the next clock edge
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/aes_pkg.sv
// package for the aes-128 encryption pipeline: types, s-box and round helpers
// no dependencies
package aes_pkg;

  localparam int unsigned NumRounds = 10;
  localparam int unsigned WordWidth = 64;
  localparam int unsigned BlockWidth = 128;
  localparam int unsigned CfgAddrWidth = 4;

  // register byte addresses
  localparam logic [CfgAddrWidth-1:0] AddrKeyHigh = 4'h0;
  localparam logic [CfgAddrWidth-1:0] AddrKeyLow = 4'h8;

  typedef logic [BlockWidth-1:0] block_t;

  typedef struct packed {
    logic   valid;
    block_t state;
    block_t rkey;
  } stage_t;

  function automatic logic [7:0] sbox(input logic [7:0] x);
    logic [7:0] t [256];
    t = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };
    return t[x];
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  // byte i of a block sits at bits 127-8i downto 120-8i
  function automatic logic [7:0] get_byte(input block_t b, input int unsigned i);
    return b[BlockWidth-1-8*i -: 8];
  endfunction

  function automatic logic [7:0] rcon(input int unsigned r);
    logic [7:0] c;
    c = 8'h01;
    for (int unsigned k = 1; k < r; k++) c = xtime(c);
    return c;
  endfunction

  // subbytes, shiftrows and, unless last, mixcolumns
  function automatic block_t round_fn(input block_t s, input logic last);
    logic [7:0] o [16];
    logic [7:0] a0, a1, a2, a3, all;
    block_t res;
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++)
        o[c*4+r] = sbox(get_byte(s, ((c + r) % 4) * 4 + r));
    if (!last) begin
      for (int c = 0; c < 4; c++) begin
        a0 = o[4*c]; a1 = o[4*c+1]; a2 = o[4*c+2]; a3 = o[4*c+3];
        all = a0 ^ a1 ^ a2 ^ a3;
        o[4*c]   = a0 ^ all ^ xtime(a0 ^ a1);
        o[4*c+1] = a1 ^ all ^ xtime(a1 ^ a2);
        o[4*c+2] = a2 ^ all ^ xtime(a2 ^ a3);
        o[4*c+3] = a3 ^ all ^ xtime(a3 ^ a0);
      end
    end
    for (int i = 0; i < 16; i++) res[BlockWidth-1-8*i -: 8] = o[i];
    return res;
  endfunction

  function automatic block_t next_key(input block_t k, input logic [7:0] rc);
    logic [31:0] w [4];
    logic [31:0] t;
    block_t res;
    for (int i = 0; i < 4; i++) w[i] = k[BlockWidth-1-32*i -: 32];
    t = {sbox(w[3][23:16]) ^ rc, sbox(w[3][15:8]), sbox(w[3][7:0]), sbox(w[3][31:24])};
    w[0] = w[0] ^ t;
    for (int i = 1; i < 4; i++) w[i] = w[i] ^ w[i-1];
    for (int i = 0; i < 4; i++) res[BlockWidth-1-32*i -: 32] = w[i];
    return res;
  endfunction

endpackage

// File: rtl/aes_if.sv
// valid/ready channel carrying one 128-bit block as two 64-bit halves
// depends on aes_pkg
interface aes_if;
  import aes_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [WordWidth-1:0] data_high;
  logic [WordWidth-1:0] data_low;
  modport source (output valid, data_high, data_low, input ready);
  modport sink (input valid, data_high, data_low, output ready);
endinterface

// File: rtl/aes_round_pipe.sv
// unrolled round pipeline: a register stage for the initial key addition and one per round, stalls as a whole
// depends on aes_pkg and assert_macros.svh
`include "assert_macros.svh"
module aes_round_pipe #(
  parameter int unsigned Rounds = aes_pkg::NumRounds
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           advance_i,
  input  aes_pkg::stage_t entry_i,
  output aes_pkg::stage_t exit_o
);
  import aes_pkg::*;

  stage_t stage_q [Rounds+1];
  stage_t stage_d [Rounds+1];

  always_comb begin
    stage_d[0] = entry_i;
    stage_d[0].state = entry_i.state ^ entry_i.rkey;
    for (int r = 1; r <= Rounds; r++) begin
      stage_d[r].valid = stage_q[r-1].valid;
      stage_d[r].rkey  = next_key(stage_q[r-1].rkey, rcon(r));
      stage_d[r].state = round_fn(stage_q[r-1].state, r == Rounds) ^ stage_d[r].rkey;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r <= Rounds; r++) stage_q[r] <= '0;
    end else if (advance_i) begin
      for (int r = 0; r <= Rounds; r++) stage_q[r] <= stage_d[r];
    end
  end

  assign exit_o = stage_q[Rounds];

  `ASSERT_NEXT(a_hold_valid, clk_i, rst_ni, !advance_i,
    exit_o.valid == $past(exit_o.valid), "stalled pipeline changed its output valid")
  `ASSERT_NEXT(a_shift, clk_i, rst_ni, advance_i,
    stage_q[1].valid == $past(stage_q[0].valid), "valid bit did not move with its word")
  `ASSERT_NEXT(a_data_hold, clk_i, rst_ni, !advance_i && exit_o.valid,
    $stable(exit_o.state), "stalled result changed")
endmodule

// File: rtl/aes128_block_encrypt.sv
// aes-128 block encryption top level: key registers, apb port and round pipeline
// depends on aes_pkg, aes_if, aes_round_pipe and assert_macros.svh
// Encrypts one 128-bit word per cycle under AES-128 unless stalled. Each accepted
// word passes through eleven register stages (initial key addition, nine full
// rounds, final round), and a new word may enter every cycle unless stalled.
// The pipeline stalls as a whole when the result is not taken. The key is
// written over apb at byte address 0 (bytes 0..7) and 8 (bytes 8..15), 64-bit
// data; write it only while no word is in flight.
`include "assert_macros.svh"
module aes128_block_encrypt #(
  parameter int unsigned Rounds = aes_pkg::NumRounds
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  aes_if.sink                               plain,
  aes_if.source                             cipher,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [aes_pkg::CfgAddrWidth-1:0]  paddr,
  input  logic [aes_pkg::WordWidth-1:0]     pwdata,
  output logic [aes_pkg::WordWidth-1:0]     prdata,
  output logic                              pready
);
  import aes_pkg::*;

  logic [WordWidth-1:0] key_high_q, key_low_q;
  logic                 advance;
  stage_t               entry, exit_w;

  // key registers, written on the access phase
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_high_q <= '0;
      key_low_q  <= '0;
    end else if (psel && penable && pwrite) begin
      case (paddr)
        AddrKeyHigh: key_high_q <= pwdata;
        AddrKeyLow:  key_low_q  <= pwdata;
        default: ;
      endcase
    end
  end

  assign pready = 1'b1;
  always_comb begin
    case (paddr)
      AddrKeyHigh: prdata = key_high_q;
      AddrKeyLow:  prdata = key_low_q;
      default:     prdata = '0;
    endcase
  end

  // whole pipeline moves unless a finished word waits at the output
  assign advance     = cipher.ready || !exit_w.valid;
  assign plain.ready = advance;

  assign entry.valid = plain.valid;
  assign entry.state = {plain.data_high, plain.data_low};
  assign entry.rkey  = {key_high_q, key_low_q};

  aes_round_pipe #(.Rounds(Rounds)) u_pipe (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .entry_i   (entry),
    .exit_o    (exit_w)
  );

  assign cipher.valid     = exit_w.valid;
  assign cipher.data_high = exit_w.state[BlockWidth-1:WordWidth];
  assign cipher.data_low  = exit_w.state[WordWidth-1:0];

  `ASSERT_ALWAYS(a_ready_when_empty, clk_i, rst_ni, exit_w.valid || plain.ready,
    "input stalled while output empty")
  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, cipher.valid && !cipher.ready,
    cipher.valid && $stable(cipher.data_low), "waiting result dropped or changed")
  `ASSERT_ALWAYS(a_pready, clk_i, rst_ni, pready, "pready low")
endmodule

// File: tb/sv/aes128_block_encrypt_tb.sv
// self-checking bench for the aes-128 encryption pipeline: apb key writes,
// directed and random plaintext words, scoreboard with its own cipher model
// depends on aes_pkg, aes_if and aes128_block_encrypt
module aes128_block_encrypt_tb;
  import aes_pkg::*;

  localparam int unsigned RandWords = 800;
  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned DrainCycles = 16;

  typedef logic [127:0] blk_t;

  // scoreboard: keeps the expected ciphertexts in order of acceptance
  class cipher_scoreboard;
    blk_t expected_q[$];
    int unsigned n_checked;
    int unsigned n_errors;
    blk_t key;

    function automatic logic [7:0] gmul2(logic [7:0] a);
      return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    // s-box worked out from the field inverse and the affine map
    function automatic logic [7:0] sub_byte(logic [7:0] x);
      logic [7:0] inv, p, a, b, r;
      inv = 8'h00;
      if (x != 0) begin
        for (int y = 1; y < 256; y++) begin
          p = 8'h00; a = x; b = y[7:0];
          for (int i = 0; i < 8; i++) begin
            if (b[0]) p ^= a;
            a = gmul2(a);
            b = b >> 1;
          end
          if (p == 8'h01) begin
            inv = y[7:0];
            break;
          end
        end
      end
      r = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]} ^ {inv[4:0], inv[7:5]}
          ^ {inv[3:0], inv[7:4]} ^ 8'h63;
      return r;
    endfunction

    function automatic blk_t encrypt(blk_t pt);
      logic [7:0] s[16], o[16], rk[16], t[4];
      logic [7:0] a0, a1, a2, a3, all, rc;
      blk_t res;
      rc = 8'h01;
      for (int i = 0; i < 16; i++) begin
        s[i] = pt[127-8*i -: 8];
        rk[i] = key[127-8*i -: 8];
        s[i] ^= rk[i];
      end
      for (int r = 1; r <= 10; r++) begin
        for (int c = 0; c < 4; c++)
          for (int w = 0; w < 4; w++) o[c*4+w] = sub_byte(s[((c + w) % 4) * 4 + w]);
        if (r < 10) begin
          for (int c = 0; c < 4; c++) begin
            a0 = o[4*c]; a1 = o[4*c+1]; a2 = o[4*c+2]; a3 = o[4*c+3];
            all = a0 ^ a1 ^ a2 ^ a3;
            o[4*c]   = a0 ^ all ^ gmul2(a0 ^ a1);
            o[4*c+1] = a1 ^ all ^ gmul2(a1 ^ a2);
            o[4*c+2] = a2 ^ all ^ gmul2(a2 ^ a3);
            o[4*c+3] = a3 ^ all ^ gmul2(a3 ^ a0);
          end
        end
        t[0] = sub_byte(rk[13]) ^ rc;
        t[1] = sub_byte(rk[14]);
        t[2] = sub_byte(rk[15]);
        t[3] = sub_byte(rk[12]);
        for (int i = 0; i < 4; i++) rk[i] ^= t[i];
        for (int i = 4; i < 16; i++) rk[i] ^= rk[i-4];
        rc = gmul2(rc);
        for (int i = 0; i < 16; i++) s[i] = o[i] ^ rk[i];
      end
      for (int i = 0; i < 16; i++) res[127-8*i -: 8] = s[i];
      return res;
    endfunction

    task report_mismatch(string what, blk_t exp_blk, blk_t got_blk);
      n_errors++;
      $display("mismatch %s: expected %032h got %032h", what, exp_blk, got_blk);
    endtask

    function void note_plain(blk_t pt);
      expected_q.push_back(encrypt(pt));
    endfunction

    task check_cipher(logic [63:0] hi, logic [63:0] lo);
      blk_t exp_blk;
      n_checked++;
      if (expected_q.size() == 0) begin
        report_mismatch("cipher word with nothing expected", 128'h0, {hi, lo});
        return;
      end
      exp_blk = expected_q.pop_front();
      if (hi !== exp_blk[127:64]) report_mismatch("cipher_high", exp_blk, {hi, lo});
      if (lo !== exp_blk[63:0]) report_mismatch("cipher_low", exp_blk, {hi, lo});
    endtask
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [CfgAddrWidth-1:0] paddr = '0;
  logic [WordWidth-1:0] pwdata = '0;
  logic [WordWidth-1:0] prdata;
  logic pready;

  aes_if plain_ch ();
  aes_if cipher_ch ();

  cipher_scoreboard sb = new();
  int unsigned cycles;
  int unsigned n_sent;
  int unsigned n_keys;

  initial begin
    plain_ch.valid = 1'b0;
    plain_ch.data_high = '0;
    plain_ch.data_low = '0;
    cipher_ch.ready = 1'b0;
  end

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  aes128_block_encrypt u_top (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .plain   (plain_ch.sink),
    .cipher  (cipher_ch.source),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // apb write: setup cycle then access cycle, held until pready, then back to idle
  task automatic apb_write(logic [CfgAddrWidth-1:0] addr, logic [63:0] data);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    @(posedge clk_i);
  endtask

  // both key halves, mirrored into the scoreboard
  task automatic load_key(blk_t k);
    apb_write(AddrKeyHigh, k[127:64]);
    apb_write(AddrKeyLow, k[63:0]);
    sb.key = k;
    n_keys++;
    @(posedge clk_i);
  endtask

  // offer one plaintext word after a random gap, wait for the handshake;
  // valid stays high afterwards so back-to-back words need no idle cycle
  task automatic send_plain(blk_t pt, bit no_gap);
    int unsigned gap;
    gap = no_gap ? 0 : $urandom_range(0, 19);
    if (gap != 0) begin
      plain_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    plain_ch.valid <= 1'b1;
    plain_ch.data_high <= pt[127:64];
    plain_ch.data_low <= pt[63:0];
    @(posedge clk_i);
    while (!plain_ch.ready) @(posedge clk_i);
    sb.note_plain(pt);
    n_sent++;
  endtask

  // wait until every expected word is back, then let the pipe go quiet
  task automatic drain;
    plain_ch.valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  function automatic blk_t rand_blk();
    return {$urandom, $urandom, $urandom, $urandom};
  endfunction

  // receiver: random stalls, with the odd stretch of always-ready
  bit rx_eager;
  initial begin
    int unsigned stall;
    @(posedge rst_ni);
    forever begin
      stall = rx_eager ? 0 : $urandom_range(0, 19);
      if (stall != 0) begin
        cipher_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      cipher_ch.ready <= 1'b1;
      @(posedge clk_i);
      while (!cipher_ch.valid) @(posedge clk_i);
      sb.check_cipher(cipher_ch.data_high, cipher_ch.data_low);
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    blk_t k;
    cycles = 0; n_sent = 0; n_keys = 0; rx_eager = 0;
    sb.key = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset key of zero, then the fips-197 example key
    send_plain('0, 0);
    send_plain('1, 0);
    drain();
    load_key(128'h000102030405060708090a0b0c0d0e0f);
    send_plain(128'h00112233445566778899aabbccddeeff, 0);
    send_plain(128'h0, 0);
    send_plain({128{1'b1}}, 0);
    send_plain(128'h8000_0000_0000_0000_0000_0000_0000_0001, 0);
    drain();
    load_key({128{1'b1}});
    for (int i = 0; i < 8; i++) send_plain(128'h1 << (i * 16 + 7), 1);
    send_plain('0, 0);
    drain();
    load_key(128'h2b7e151628aed2a6abf7158809cf4f3c);
    send_plain(128'h3243f6a8885a308d313198a2e0370734, 0);
    drain();

    // random phases, each under a fresh key, some phases back-to-back
    for (int ph = 0; ph < 8; ph++) begin
      k = (ph == 7) ? '0 : rand_blk();
      load_key(k);
      rx_eager = (ph % 3 == 1);
      for (int i = 0; i < RandWords / 8; i++) send_plain(rand_blk(), (ph % 3 == 2));
      drain();
    end
    rx_eager = 1;
    drain();

    $display("sent %0d plaintext words under %0d keys, %0d cipher words checked",
             n_sent, n_keys, sb.n_checked);
    if (sb.n_errors == 0 && sb.expected_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+rtl
rtl/aes_pkg.sv
rtl/aes_if.sv
rtl/aes_round_pipe.sv
rtl/aes128_block_encrypt.sv
tb/sv/aes128_block_encrypt_tb.sv
